// ===== hw/rtl/month_calendar_grid_defines.svh =====
// ----------------------------------------------------------------------------
// month calendar grid assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef MONTH_CALENDAR_GRID_DEFINES_SVH
`define MONTH_CALENDAR_GRID_DEFINES_SVH

// same-cycle implication
`define MCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mcg_pkg.sv =====
// ----------------------------------------------------------------------------
// mcg_pkg
// types, constants and tables for the month calendar grid
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COL_W   = 3;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [COL_W-1:0]   COL_SAT   = 3'd6;

  // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for x below 43699
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  // floor(x / 7) = (x * DIV7_MUL) >> DIV7_SHIFT for x below 43690
  localparam logic [14:0] DIV7_MUL     = 15'd18725;
  localparam int unsigned DIV7_SHIFT   = 17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QY,
    ST_QYY,
    ST_SUM,
    ST_MOD,
    ST_REM,
    ST_EMIT
  } mcg_state_t;

  typedef struct packed {
    logic load;
    logic q_y;
    logic q_yy;
    logic sum;
    logic mod;
    logic rem;
    logic advance;
  } mcg_cmd_t;

  typedef struct packed {
    logic bad;
    logic last;
  } mcg_status_t;

  function automatic logic [COL_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [COL_W-1:0] r;
    unique case (m)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd2:                     r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
      default:                  r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/mcg_req_if.sv =====
// ----------------------------------------------------------------------------
// mcg_req_if
// request channel: month and year
// ----------------------------------------------------------------------------
interface mcg_req_if import mcg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MONTH_W-1:0] month_number;
  logic [YEAR_W-1:0]  year_number;

  modport source (output valid, output month_number, output year_number, input ready);
  modport sink   (input valid, input month_number, input year_number, output ready);
endinterface

// ===== hw/rtl/mcg_day_if.sv =====
// ----------------------------------------------------------------------------
// mcg_day_if
// result channel: one day cell per transfer
// ----------------------------------------------------------------------------
interface mcg_day_if import mcg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DAY_W-1:0] day_of_month;
  logic [COL_W-1:0] weekday_column;
  logic             row_end;
  logic             bad_input;
  logic             last_of_run;

  modport source (output valid, output day_of_month, output weekday_column,
                  output row_end, output bad_input, output last_of_run, input ready);
  modport sink   (input valid, input day_of_month, input weekday_column,
                  input row_end, input bad_input, input last_of_run, output ready);
endinterface

// ===== hw/rtl/mcg_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcg_ctrl
// sequencer: accept, weekday and length steps, then one cell per transfer
// ----------------------------------------------------------------------------
module mcg_ctrl import mcg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  mcg_status_t status,
  output mcg_cmd_t    cmd
);

  mcg_state_t state;
  mcg_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_QY;
        end
      end
      ST_QY: begin
        cmd.q_y    = 1'b1;
        state_next = status.bad ? ST_EMIT : ST_QYY;
      end
      ST_QYY: begin
        cmd.q_yy   = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_MOD;
      end
      ST_MOD: begin
        cmd.mod    = 1'b1;
        state_next = ST_REM;
      end
      ST_REM: begin
        cmd.rem    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/mcg_dp.sv =====
// ----------------------------------------------------------------------------
// mcg_dp
// datapath: leap rule, table weekday of the first, day and column counters
// ----------------------------------------------------------------------------
module mcg_dp import mcg_pkg::*; (
  input  logic               clk,
  input  mcg_cmd_t           cmd,
  output mcg_status_t        status,
  input  logic [MONTH_W-1:0] month_number,
  input  logic [YEAR_W-1:0]  year_number,
  output logic [DAY_W-1:0]   day_of_month,
  output logic [COL_W-1:0]   weekday_column,
  output logic               row_end,
  output logic               bad_input,
  output logic               last_of_run
);

  logic [MONTH_W-1:0] month;
  logic [YEAR_W-1:0]  year;
  logic [YEAR_W-1:0]  yy;
  logic               bad;
  logic [6:0]         q_y;
  logic [6:0]         q_yy;
  logic               leap;
  logic [14:0]        sum;
  logic [DAY_W-1:0]   len;
  logic [10:0]        q7;
  logic [DAY_W-1:0]   day;
  logic [COL_W-1:0]   col;

  logic               bad_next;
  logic [YEAR_W-1:0]  mul_a;
  logic [26:0]        prod100;
  logic [YEAR_W-1:0]  rem100;
  logic               leap_next;
  logic [14:0]        sum_next;
  logic [29:0]        prod7;
  logic [14:0]        col_wide;

  assign bad_next = (month_number < MONTH_JAN) || (month_number > MONTH_DEC) ||
                    (year_number < YEAR_MIN) || (year_number > YEAR_MAX);

  // shared divide-by-100 multiplier
  assign mul_a   = cmd.q_y ? year : yy;
  assign prod100 = 27'(mul_a) * 27'(DIV100_MUL);

  assign rem100    = year - (14'(q_y) * 14'd100);
  assign leap_next = (year[1:0] == 2'b00) && ((rem100 != '0) || (q_y[1:0] == 2'b00));

  assign sum_next = 15'(yy) + 15'(yy >> 2) - 15'(q_yy) + 15'(q_yy >> 2)
                  + 15'(month_offset(month)) + 15'd1;

  assign prod7    = 30'(sum) * 30'(DIV7_MUL);
  assign col_wide = sum - (15'(q7) * 15'd7);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      month <= month_number;
      year  <= year_number;
      yy    <= year_number - 14'((month_number < MONTH_MAR) ? 1 : 0);
      bad   <= bad_next;
      day   <= '0;
      col   <= '0;
    end
    if (cmd.q_y) begin
      q_y <= prod100[DIV100_SHIFT+6:DIV100_SHIFT];
    end
    if (cmd.q_yy) begin
      q_yy <= prod100[DIV100_SHIFT+6:DIV100_SHIFT];
      leap <= leap_next;
    end
    if (cmd.sum) begin
      sum <= sum_next;
      len <= month_days(month, leap && (month == MONTH_FEB));
    end
    if (cmd.mod) begin
      q7 <= prod7[DIV7_SHIFT+10:DIV7_SHIFT];
    end
    if (cmd.rem) begin
      col <= col_wide[COL_W-1:0];
      day <= 5'd1;
    end
    if (cmd.advance) begin
      day <= day + 5'd1;
      col <= (col == COL_SAT) ? '0 : col + 3'd1;
    end
  end

  assign status.bad  = bad;
  assign status.last = bad || (day == len);

  assign day_of_month   = day;
  assign weekday_column = col;
  assign row_end        = !bad && (col == COL_SAT);
  assign bad_input      = bad;
  assign last_of_run    = status.last;

endmodule

// ===== hw/rtl/month_calendar_grid.sv =====
// ----------------------------------------------------------------------------
// month_calendar_grid
// lays out one Gregorian month as a stream of day cells
// ----------------------------------------------------------------------------
// Each request (month, year) yields one cell per day, day 1 first, with its
// weekday column (0 = Sunday), a row end mark on Saturday and a last mark on
// the final day; an invalid month or a year outside 1..9999 yields a single
// cell with bad_input and last_of_run set. After a request transfer the block
// works out the leap rule and the weekday of the first in states QY, QYY, SUM,
// MOD and REM (a shared constant multiplier for the divisions by 100, then a
// multiply for the reduction modulo 7), then shows one cell per cycle while
// the sink is ready; an invalid request goes from QY straight to its cell.
// The next request is taken once the last cell has transferred.
// ----------------------------------------------------------------------------
module month_calendar_grid import mcg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mcg_req_if.sink   req,
  mcg_day_if.source rsp
);

  mcg_cmd_t    cmd;
  mcg_status_t status;

  mcg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mcg_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .month_number   (req.month_number),
    .year_number    (req.year_number),
    .day_of_month   (rsp.day_of_month),
    .weekday_column (rsp.weekday_column),
    .row_end        (rsp.row_end),
    .bad_input      (rsp.bad_input),
    .last_of_run    (rsp.last_of_run)
  );

endmodule

// ===== hw/rtl/mcg_checker.sv =====
// ----------------------------------------------------------------------------
// mcg_checker
// port-level checks on the calendar cell stream
// ----------------------------------------------------------------------------
`include "month_calendar_grid_defines.svh"

module mcg_checker import mcg_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [DAY_W-1:0] day_of_month,
  input logic [COL_W-1:0] weekday_column,
  input logic             row_end,
  input logic             bad_input,
  input logic             last_of_run
);

  logic mid_run;

  assign mid_run = rsp_valid && rsp_ready && !last_of_run;

  `MCG_ASSERT_NOW(a_bad_cell, rsp_valid && bad_input, (day_of_month == '0) && last_of_run && !row_end, "bad request cell malformed")
  `MCG_ASSERT_NOW(a_no_overlap, rsp_valid, !req_ready, "request taken while cells pending")
  `MCG_ASSERT_NEXT(a_day_step, mid_run, rsp_valid && (day_of_month == $past(day_of_month) + 5'd1), "day sequence broken")
  `MCG_ASSERT_NEXT(a_col_step, mid_run, weekday_column == (($past(weekday_column) == COL_SAT) ? 3'd0 : $past(weekday_column) + 3'd1), "weekday sequence broken")

endmodule

bind month_calendar_grid mcg_checker u_mcg_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .day_of_month   (rsp.day_of_month),
  .weekday_column (rsp.weekday_column),
  .row_end        (rsp.row_end),
  .bad_input      (rsp.bad_input),
  .last_of_run    (rsp.last_of_run)
);

// ===== tb/mcg_calendar_checker.sv =====
// ----------------------------------------------------------------------------
// mcg_calendar_checker
// watches the request and day channels of the month calendar grid, works out
// the day cells each accepted month request should produce, and compares every
// transferred cell field by field against the oldest outstanding cell
// ----------------------------------------------------------------------------
module mcg_calendar_checker import mcg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mcg_req_if          req,
  mcg_day_if          rsp,
  output int unsigned mismatches,
  output int unsigned cells_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned EXP_DEPTH = 64;

  typedef struct packed {
    logic [DAY_W-1:0] day;
    logic [COL_W-1:0] col;
    logic             row_end;
    logic             bad;
    logic             last;
  } day_cell_t;

  day_cell_t   expected_cells[EXP_DEPTH];
  logic [5:0]  exp_wr;
  logic [5:0]  exp_rd;
  int unsigned exp_count;

  initial begin
    mismatches    = 0;
    cells_pending = 0;
    exp_wr        = '0;
    exp_rd        = '0;
    exp_count     = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void add_expected(input day_cell_t e);
    expected_cells[exp_wr] = e;
    exp_wr    = exp_wr + 6'd1;
    exp_count = exp_count + 1;
  endfunction

  function automatic void predict_month(input logic [MONTH_W-1:0] m,
                                        input logic [YEAR_W-1:0] y);
    day_cell_t   entry;
    int unsigned yy;
    int unsigned len;
    int unsigned col;
    int unsigned lead;
    logic        leap;
    entry = '0;
    if (m < MONTH_JAN || m > MONTH_DEC || y < YEAR_MIN || y > YEAR_MAX) begin
      entry.bad  = 1'b1;
      entry.last = 1'b1;
      add_expected(entry);
    end else begin
      leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
      case (m)
        4'd1:    begin lead = 0; len = 31; end
        4'd2:    begin lead = 3; len = leap ? 29 : 28; end
        4'd3:    begin lead = 2; len = 31; end
        4'd4:    begin lead = 5; len = 30; end
        4'd5:    begin lead = 0; len = 31; end
        4'd6:    begin lead = 3; len = 30; end
        4'd7:    begin lead = 5; len = 31; end
        4'd8:    begin lead = 1; len = 31; end
        4'd9:    begin lead = 4; len = 30; end
        4'd10:   begin lead = 6; len = 31; end
        4'd11:   begin lead = 2; len = 30; end
        default: begin lead = 4; len = 31; end
      endcase
      // january and february count against the previous year
      yy  = y - ((m < MONTH_MAR) ? 1 : 0);
      col = (yy + yy / 4 - yy / 100 + yy / 400 + lead + 1) % 7;
      for (int unsigned d = 1; d <= len; d++) begin
        entry.day     = d[DAY_W-1:0];
        entry.col     = col[COL_W-1:0];
        entry.row_end = (col == COL_SAT);
        entry.bad     = 1'b0;
        entry.last    = (d == len);
        add_expected(entry);
        col = (col == COL_SAT) ? 0 : col + 1;
      end
    end
  endfunction

  always @(posedge clk) begin
    day_cell_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (exp_count == 0) begin
          report_mismatch("unexpected cell, day", 32'(rsp.day_of_month), 0);
        end else begin
          want      = expected_cells[exp_rd];
          exp_rd    = exp_rd + 6'd1;
          exp_count = exp_count - 1;
          if (rsp.day_of_month !== want.day)
            report_mismatch("day_of_month", 32'(rsp.day_of_month), 32'(want.day));
          if (rsp.weekday_column !== want.col)
            report_mismatch("weekday_column", 32'(rsp.weekday_column), 32'(want.col));
          if (rsp.row_end !== want.row_end)
            report_mismatch("row_end", 32'(rsp.row_end), 32'(want.row_end));
          if (rsp.bad_input !== want.bad)
            report_mismatch("bad_input", 32'(rsp.bad_input), 32'(want.bad));
          if (rsp.last_of_run !== want.last)
            report_mismatch("last_of_run", 32'(rsp.last_of_run), 32'(want.last));
        end
      end
      if (req.valid && req.ready) begin
        predict_month(req.month_number, req.year_number);
      end
    end
    cells_pending <= exp_count;
  end

endmodule

// ===== tb/tb_month_calendar_grid.sv =====
// ----------------------------------------------------------------------------
// tb_month_calendar_grid
// drives month requests into the calendar grid and gives the verdict
// ----------------------------------------------------------------------------
// A directed set covers invalid months and years, the year range edges, the
// first months of year 1 and the leap rule around centuries; then random
// requests follow in bursts while the day sink stalls in shifting patterns,
// including one long hold-off that backs the block up. The checker beside the
// block predicts and compares every day cell.
// ----------------------------------------------------------------------------
module tb_month_calendar_grid import mcg_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_REQUESTS = 400;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = 40;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BURSTY
  } rx_mode_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic [MONTH_W-1:0] req_month = '0;
  logic [YEAR_W-1:0]  req_year  = '0;
  logic               rsp_ready = 1'b0;
  logic               hold_req  = 1'b0;

  rx_mode_t    rx_mode     = RX_OPEN;
  int unsigned rx_seg_left = 0;
  int unsigned hold_left   = 0;
  logic        hold_done   = 1'b0;
  logic [7:0]  rx_cyc      = '0;

  int unsigned mismatches;
  int unsigned cells_pending;

  mcg_req_if req ();
  mcg_day_if rsp ();

  assign req.valid        = req_valid;
  assign req.month_number = req_month;
  assign req.year_number  = req_year;
  assign rsp.ready        = rsp_ready;

  month_calendar_grid u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  mcg_calendar_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rsp           (rsp),
    .mismatches    (mismatches),
    .cells_pending (cells_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // day sink: one long hold-off on request, otherwise random stall patterns
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 8'd1;
    if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      rsp_ready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else begin
      if (rx_seg_left == 0) begin
        rx_mode     <= rx_mode_t'($urandom_range(0, 3));
        rx_seg_left <= $urandom_range(20, 300);
      end else begin
        rx_seg_left <= rx_seg_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   rsp_ready <= 1'b1;
        RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
        default:   rsp_ready <= rx_cyc[2];
      endcase
    end
  end

  task automatic offer(input logic [MONTH_W-1:0] m, input logic [YEAR_W-1:0] y);
    req_valid <= 1'b1;
    req_month <= m;
    req_year  <= y;
    do @(posedge clk); while (!req.ready);
  endtask

  initial begin
    int unsigned        sent;
    int unsigned        burst_left;
    int unsigned        kind;
    logic [MONTH_W-1:0] m;
    logic [YEAR_W-1:0]  y;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    offer(MONTH_JAN, 14'd1);
    offer(MONTH_FEB, 14'd1);
    offer(MONTH_MAR, 14'd1);
    offer(MONTH_DEC, 14'd9999);
    offer(MONTH_FEB, 14'd2000);
    offer(MONTH_FEB, 14'd1900);
    offer(MONTH_FEB, 14'd2024);
    offer(MONTH_FEB, 14'd2023);
    offer(4'd0, 14'd2024);
    offer(4'd13, 14'd2024);
    offer(4'd15, 14'd16383);
    offer(MONTH_JAN, 14'd0);
    offer(MONTH_JAN, 14'd10000);
    offer(MONTH_DEC, 14'd16383);
    offer(4'd0, 14'd0);
    for (int unsigned mm = 4; mm <= 11; mm++) begin
      offer(mm[MONTH_W-1:0], 14'd2025);
    end

    // long sink hold-off while requests keep coming
    hold_req <= 1'b1;

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst_left = $urandom_range(1, 16);
      while (burst_left != 0 && sent < RANDOM_REQUESTS) begin
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
          m = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
          y = 14'($urandom_range(0, 16383));
        end else if (kind == 2) begin
          m = 4'($urandom_range(0, 15));
          y = ($urandom_range(0, 1) == 0) ? 14'd0 : 14'($urandom_range(10000, 16383));
        end else begin
          m = 4'($urandom_range(1, 12));
          if (kind < 5)
            y = 14'($urandom_range(1, 99) * 100);
          else if (kind == 5)
            y = ($urandom_range(0, 1) == 0) ? 14'($urandom_range(1, 4)) :
                                              14'($urandom_range(9996, 9999));
          else if (kind < 8)
            y = 14'($urandom_range(1, 2499) * 4);
          else
            y = 14'($urandom_range(1, 9999));
        end
        offer(m, y);
        sent++;
        burst_left--;
      end
      req_valid <= 1'b0;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 45)) @(posedge clk);
      else
        repeat ($urandom_range(1, 4)) @(posedge clk);
    end

    do @(posedge clk); while (cells_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && cells_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
